// ===== rtl/tpt_pkg.sv =====
// shared constants and types for the track point time resampler
// no dependencies
package tpt_pkg;

  localparam int MAX_FILL_D       = 62;
  localparam int TIME_FRAC_BITS_D = 16;
  localparam int COORD_WIDTH_D    = 32;
  localparam int FILL_W           = 6;
  localparam int DIV_STEPS        = 64;
  localparam int MUL_STEPS        = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT_FIRST,
    ST_FILL_START,
    ST_FILL_WAIT,
    ST_EMIT_FILL,
    ST_EMIT_NEW
  } tpt_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_FIN
  } md_phase_t;

endpackage

// ===== rtl/track_point_time_resampler.sv =====
// Resamples timed 2-D track points onto whole seconds by linear interpolation.
// Input channel in_*: one word per track point (time, x, y, new_track flag),
// accepted when in_valid is high and in_stall is low. Output channel out_*:
// one word per emitted point, taken when out_valid is high and out_stall low.
// The first point of a track is stored and gives no output. Later points give
// the stored first point (once per track), the whole-second fill points and
// then the point itself, marked by out_last_of_run.
// in_stall rises the cycle after acceptance and stays high until the last word
// of that point is in the output register; a point that only starts a track
// leaves in_stall low.
// Each fill point takes a start step, 32 multiply steps, 64 divide steps, a
// rounding step, a hand-off step and a load of the output register; the x and
// y units run side by side. The stored and new points load the output
// register straight from their emit states. The first output word is
// registered from the emit state that follows acceptance, or after the first
// fill point's multiply and divide when a fill point comes first.
// A stalled receiver holds the output register and the sequencer waits.
// Synchronous reset clears the stored point; the next point starts a track.
// depends on tpt_pkg and tpt_muldiv
module track_point_time_resampler #(
  parameter int MAX_FILL       = tpt_pkg::MAX_FILL_D,
  parameter int TIME_FRAC_BITS = tpt_pkg::TIME_FRAC_BITS_D,
  parameter int COORD_WIDTH    = tpt_pkg::COORD_WIDTH_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_point_time,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic        in_new_track,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_time,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic        out_is_original,
  output logic        out_last_of_run,
  output logic        out_gap_clipped
);
  import tpt_pkg::*;

  localparam int CW_EFF = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int CSH    = 32 - CW_EFF;
  localparam logic [31:0] TSTEP = 32'(64'd1 << TIME_FRAC_BITS);

  tpt_state_t  state_r, state_nxt;
  logic [31:0] prev_t_r, prev_x_r, prev_y_r;
  logic [31:0] new_t_r, new_x_r, new_y_r;
  logic        have_prev_r, first_sent_r;
  logic [FILL_W-1:0] fill_r;
  logic        clip_r;
  logic [31:0] fill_t_r;

  logic        ov_r;
  logic [31:0] ot_r, ox_r, oy_r;
  logic        oorig_r, olast_r, oclip_r;

  logic        accept, slot_free, restart;
  logic [32:0] tp, tn;
  logic [32:0] fill33;
  logic        gt, clip_c;
  logic [FILL_W-1:0] fill_c;
  logic [31:0] ext_px, ext_py, ext_nx, ext_ny;
  logic        md_start, mdx_done, mdy_done;
  logic [31:0] rx, ry;

  logic emit_first, emit_fill, emit_new;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign slot_free = !ov_r || !out_stall;
  assign restart   = in_new_track || !have_prev_r;

  always_comb begin
    tp     = {1'b0, prev_t_r >> TIME_FRAC_BITS};
    tn     = {1'b0, in_point_time >> TIME_FRAC_BITS};
    gt     = tn > tp + 33'd1;
    fill33 = tn - tp - 33'd1;
    clip_c = gt && (fill33 > 33'(MAX_FILL));
    fill_c = !gt ? '0 : (clip_c ? FILL_W'(MAX_FILL) : fill33[FILL_W-1:0]);
    ext_px = 32'($signed(prev_x_r << CSH) >>> CSH);
    ext_py = 32'($signed(prev_y_r << CSH) >>> CSH);
    ext_nx = 32'($signed(new_x_r << CSH) >>> CSH);
    ext_ny = 32'($signed(new_y_r << CSH) >>> CSH);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && !restart) begin
          if (!first_sent_r) state_nxt = ST_EMIT_FIRST;
          else if (fill_c != '0) state_nxt = ST_FILL_START;
          else state_nxt = ST_EMIT_NEW;
        end
      end
      ST_EMIT_FIRST: begin
        if (slot_free) state_nxt = (fill_r != '0) ? ST_FILL_START : ST_EMIT_NEW;
      end
      ST_FILL_START: state_nxt = ST_FILL_WAIT;
      ST_FILL_WAIT: begin
        if (mdx_done && mdy_done) state_nxt = ST_EMIT_FILL;
      end
      ST_EMIT_FILL: begin
        if (slot_free) state_nxt = (fill_r == FILL_W'(1)) ? ST_EMIT_NEW : ST_FILL_START;
      end
      ST_EMIT_NEW: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    emit_first = (state_r == ST_EMIT_FIRST) && slot_free;
    emit_fill  = (state_r == ST_EMIT_FILL) && slot_free;
    emit_new   = (state_r == ST_EMIT_NEW) && slot_free;
    md_start   = (state_r == ST_FILL_START);
  end

  tpt_muldiv u_mdx (
    .clk(clk), .rst_n(rst_n), .start(md_start),
    .a(ext_px), .b(ext_nx), .num(fill_t_r - prev_t_r), .den(new_t_r - prev_t_r),
    .done(mdx_done), .result(rx)
  );

  tpt_muldiv u_mdy (
    .clk(clk), .rst_n(rst_n), .start(md_start),
    .a(ext_py), .b(ext_ny), .num(fill_t_r - prev_t_r), .den(new_t_r - prev_t_r),
    .done(mdy_done), .result(ry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      have_prev_r  <= 1'b0;
      first_sent_r <= 1'b0;
      prev_t_r     <= '0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      ov_r         <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && restart) begin
        prev_t_r     <= in_point_time;
        prev_x_r     <= in_pos_x;
        prev_y_r     <= in_pos_y;
        have_prev_r  <= 1'b1;
        first_sent_r <= 1'b0;
      end
      if (emit_new) begin
        prev_t_r     <= new_t_r;
        prev_x_r     <= new_x_r;
        prev_y_r     <= new_y_r;
        first_sent_r <= 1'b1;
      end
      if (emit_first || emit_fill || emit_new) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
    if (accept) begin
      new_t_r  <= in_point_time;
      new_x_r  <= in_pos_x;
      new_y_r  <= in_pos_y;
      fill_r   <= fill_c;
      clip_r   <= clip_c;
      fill_t_r <= ((prev_t_r >> TIME_FRAC_BITS) << TIME_FRAC_BITS) + TSTEP;
    end
    if (emit_fill) begin
      fill_r   <= fill_r - FILL_W'(1);
      fill_t_r <= fill_t_r + TSTEP;
    end
    if (emit_first) begin
      ot_r <= prev_t_r; ox_r <= prev_x_r; oy_r <= prev_y_r;
      oorig_r <= 1'b1; olast_r <= 1'b0; oclip_r <= clip_r;
    end else if (emit_fill) begin
      ot_r <= fill_t_r; ox_r <= rx; oy_r <= ry;
      oorig_r <= 1'b0; olast_r <= 1'b0; oclip_r <= clip_r;
    end else if (emit_new) begin
      ot_r <= new_t_r; ox_r <= new_x_r; oy_r <= new_y_r;
      oorig_r <= 1'b1; olast_r <= 1'b1; oclip_r <= clip_r;
    end
  end

  assign out_valid       = ov_r;
  assign out_time        = ot_r;
  assign out_x           = ox_r;
  assign out_y           = oy_r;
  assign out_is_original = oorig_r;
  assign out_last_of_run = olast_r;
  assign out_gap_clipped = oclip_r;

endmodule

// ===== rtl/tpt_muldiv.sv =====
// bit-serial round(|b-a| * num / den) and offset from a, one bit per cycle
// depends on tpt_pkg
module tpt_muldiv (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] result
);
  import tpt_pkg::*;

  md_phase_t   phase_r, phase_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] mag_r, mag_nxt;
  logic [31:0] den_r, den_nxt;
  logic [31:0] a_r, a_nxt;
  logic        neg_r, neg_nxt;
  logic        done_r, done_nxt;
  logic [31:0] res_r, res_nxt;

  logic signed [32:0] diff;
  logic [32:0]        sum;
  logic [32:0]        r2;
  logic               ge;
  logic               rnd;
  logic [31:0]        q;

  always_comb begin
    diff      = {b[31], b} - {a[31], a};
    sum       = {1'b0, prod_r[63:32]} + (prod_r[0] ? {1'b0, mag_r} : 33'd0);
    r2        = {rem_r, prod_r[63]};
    ge        = r2 >= {1'b0, den_r};
    rnd       = {rem_r, 1'b0} >= {1'b0, den_r};
    q         = prod_r[31:0] + {31'd0, rnd};
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    mag_nxt   = mag_r;
    den_nxt   = den_r;
    a_nxt     = a_r;
    neg_nxt   = neg_r;
    done_nxt  = 1'b0;
    res_nxt   = res_r;
    case (phase_r)
      MD_IDLE: begin
        if (start) begin
          neg_nxt   = diff[32];
          mag_nxt   = diff[32] ? 32'(-diff) : diff[31:0];
          prod_nxt  = {32'd0, num};
          den_nxt   = den;
          a_nxt     = a;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          phase_nxt = MD_MUL;
        end
      end
      MD_MUL: begin
        prod_nxt = {sum, prod_r[31:1]};
        cnt_nxt  = cnt_r + 6'd1;
        if (cnt_r == 6'(MUL_STEPS - 1)) begin
          cnt_nxt   = '0;
          phase_nxt = MD_DIV;
        end
      end
      MD_DIV: begin
        rem_nxt  = ge ? 32'(r2 - {1'b0, den_r}) : r2[31:0];
        prod_nxt = {prod_r[62:0], ge};
        cnt_nxt  = cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_STEPS - 1)) begin
          phase_nxt = MD_FIN;
        end
      end
      MD_FIN: begin
        res_nxt   = neg_r ? a_r - q : a_r + q;
        done_nxt  = 1'b1;
        phase_nxt = MD_IDLE;
      end
      default: phase_nxt = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= MD_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    mag_r  <= mag_nxt;
    den_r  <= den_nxt;
    a_r    <= a_nxt;
    neg_r  <= neg_nxt;
    res_r  <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule
